FILE: hw/rtl/pgpd_pkg.sv
// Package for the packet header deframer: codes, enums, structs and constants.
// No dependencies; every module of the block and of the testbench imports it.
package pgpd_pkg;

	// Fixed field widths.
	localparam int unsigned CHUNK_W     = 25;
	localparam int unsigned ACC_W       = 32;
	localparam int unsigned APB_ADDR_W  = 3;
	localparam int unsigned APB_DATA_W  = 32;

	// Reset value of the chunk length limit: 16 MiB.
	localparam logic [CHUNK_W-1:0] LEN_LIMIT_RESET = CHUNK_W'(16 * 1024 * 1024);

	// Default for the length counter width.
	localparam int unsigned LENGTH_WIDTH_DEFAULT = 25;

	// Header byte bits and new-format length byte boundaries.
	localparam int unsigned HDR_VALID_BIT  = 7;
	localparam int unsigned HDR_NEWFMT_BIT = 6;
	localparam logic [1:0]  OLD_LEN_1      = 2'd0;
	localparam logic [1:0]  OLD_LEN_2      = 2'd1;
	localparam logic [1:0]  OLD_LEN_CTX    = 2'd3;
	localparam logic [7:0]  NEW_ONE_MAX    = 8'd191;
	localparam logic [7:0]  NEW_TWO_MAX    = 8'd223;
	localparam logic [7:0]  NEW_FIVE       = 8'd255;
	localparam logic [ACC_W-1:0] NEW_TWO_OFFSET = ACC_W'(192);

	// Register indexes on the configuration port (paddr bit 2).
	localparam logic REG_CTX_EN    = 1'b0;
	localparam logic REG_LEN_LIMIT = 1'b1;

	// Input action codes.
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_EOF  = 1'b1;

	typedef enum logic [2:0] {
		PH_HDR,
		PH_NEWLEN,
		PH_TWO,
		PH_MULTI,
		PH_BODY,
		PH_CONTEXT
	} phase_t;

	typedef enum logic [1:0] {
		K_BODY,
		K_HEADER,
		K_ERROR,
		K_END
	} kind_t;

	typedef enum logic [1:0] {
		LK_DEFINITE,
		LK_PARTIAL,
		LK_CONTEXT
	} lk_t;

	typedef enum logic [2:0] {
		E_NONE,
		E_NOT_HEADER,
		E_BAD_LENGTH,
		E_NO_CONTEXT,
		E_TRUNCATED
	} err_t;

	typedef struct packed {
		logic               ctx_en;
		logic [CHUNK_W-1:0] len_limit;
	} cfg_t;

	typedef struct packed {
		logic               valid;
		kind_t              kind;
		logic [5:0]         tag;
		logic [7:0]         body;
		logic [CHUNK_W-1:0] len;
		lk_t                lk;
		logic               last;
		err_t               err;
	} res_t;

endpackage

FILE: hw/rtl/pgpd_in_if.sv
// Input stream channel of the packet header deframer: valid/ready plus one item.
// Depends on nothing.
interface pgpd_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;

	modport source (output valid, action, data_byte, input ready);
	modport sink   (input valid, action, data_byte, output ready);
endinterface

FILE: hw/rtl/pgpd_out_if.sv
// Result channel of the packet header deframer: valid/ready plus one result item.
// Depends on nothing.
interface pgpd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [5:0]  packet_tag;
	logic [7:0]  body_byte;
	logic [24:0] chunk_length;
	logic [1:0]  length_kind;
	logic        last_in_packet;
	logic [2:0]  error_code;

	modport source (output valid, kind, packet_tag, body_byte, chunk_length, length_kind,
		last_in_packet, error_code, input ready);
	modport sink   (input valid, kind, packet_tag, body_byte, chunk_length, length_kind,
		last_in_packet, error_code, output ready);
endinterface

FILE: hw/rtl/pgpd_apb_regs.sv
// APB configuration registers of the packet header deframer.
// Depends on pgpd_pkg.
module pgpd_apb_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pgpd_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [pgpd_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [pgpd_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	output pgpd_pkg::cfg_t                   cfg
);
	import pgpd_pkg::*;

	logic               ctx_en_q;
	logic [CHUNK_W-1:0] len_limit_q;
	logic               wr_en;
	logic               reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	// Registers are word spaced; the low address bits are ignored.
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_en_q    <= 1'b0;
			len_limit_q <= LEN_LIMIT_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CTX_EN:    ctx_en_q    <= pwdata[0];
				REG_LEN_LIMIT: len_limit_q <= pwdata[CHUNK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CTX_EN:    prdata = {{(APB_DATA_W-1){1'b0}}, ctx_en_q};
			REG_LEN_LIMIT: prdata = {{(APB_DATA_W-CHUNK_W){1'b0}}, len_limit_q};
			default:       prdata = '0;
		endcase
	end

	assign cfg.ctx_en    = ctx_en_q;
	assign cfg.len_limit = len_limit_q;

endmodule

FILE: hw/rtl/pgpd_hdr_fsm.sv
// Header parsing state machine of the packet header deframer. It holds the
// parse state and turns one registered item into at most one result.
// Depends on pgpd_pkg.
module pgpd_hdr_fsm #(
	parameter int unsigned LENGTH_WIDTH = pgpd_pkg::LENGTH_WIDTH_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic           action,
	input  logic [7:0]     data_byte,
	input  pgpd_pkg::cfg_t cfg,
	output pgpd_pkg::res_t res
);
	import pgpd_pkg::*;

	localparam logic [ACC_W-1:0] LEN_MASK = ACC_W'((64'd1 << LENGTH_WIDTH) - 64'd1);

	phase_t                  phase_q, phase_d;
	logic [5:0]              tag_q, tag_d;
	logic [LENGTH_WIDTH-1:0] rem_q, rem_d;
	logic [ACC_W-1:0]        acc_q, acc_d;
	logic [2:0]              left_q, left_d;
	lk_t                     ck_q, ck_d;
	logic                    err_q, err_d;

	logic                    live;
	logic [5:0]              hdr_tag;
	logic [2:0]              old_left;
	logic [ACC_W-1:0]        max32;
	logic [ACC_W-1:0]        lim;
	logic                    fin_go;
	logic                    fin_part;
	logic [ACC_W-1:0]        fin_len;
	logic                    fin_over;
	logic                    fin_zero;
	logic                    chained;
	logic [LENGTH_WIDTH-1:0] rem_dec;
	logic [2:0]              left_dec;

	assign live     = step && !err_q;
	assign hdr_tag  = data_byte[HDR_NEWFMT_BIT] ? data_byte[5:0] : {2'b00, data_byte[5:2]};
	assign max32    = {{(ACC_W-CHUNK_W){1'b0}}, cfg.len_limit};
	assign lim      = (max32 > LEN_MASK) ? LEN_MASK : max32;
	assign chained  = (ck_q == LK_PARTIAL);
	assign rem_dec  = rem_q - LENGTH_WIDTH'(1);
	assign left_dec = left_q - 3'd1;

	always_comb begin
		unique case (data_byte[1:0])
			OLD_LEN_1: old_left = 3'd1;
			OLD_LEN_2: old_left = 3'd2;
			default:   old_left = 3'd4;
		endcase
	end

	// Length that completes in this cycle, if any.
	always_comb begin
		fin_go   = 1'b0;
		fin_part = 1'b0;
		fin_len  = '0;
		if (action == ACT_BYTE) begin
			unique case (phase_q)
				PH_NEWLEN: begin
					if (data_byte <= NEW_ONE_MAX) begin
						fin_go  = 1'b1;
						fin_len = {{(ACC_W-8){1'b0}}, data_byte};
					end else if (data_byte > NEW_TWO_MAX && data_byte != NEW_FIVE) begin
						fin_go   = 1'b1;
						fin_part = 1'b1;
						fin_len  = ACC_W'(1) << data_byte[4:0];
					end
				end
				PH_TWO: begin
					fin_go  = 1'b1;
					fin_len = acc_q + {{(ACC_W-8){1'b0}}, data_byte};
				end
				PH_MULTI: begin
					fin_go  = (left_dec == 3'd0);
					fin_len = {acc_q[ACC_W-9:0], data_byte};
				end
				default: ;
			endcase
		end
	end

	assign fin_over = fin_len > lim;
	assign fin_zero = (fin_len == '0);

	// Next state.
	always_comb begin
		phase_d = phase_q;
		tag_d   = tag_q;
		rem_d   = rem_q;
		acc_d   = acc_q;
		left_d  = left_q;
		ck_d    = ck_q;
		err_d   = err_q;
		if (action == ACT_EOF) begin
			unique case (phase_q)
				PH_HDR:     ;
				PH_CONTEXT: phase_d = PH_HDR;
				default: begin
					err_d   = 1'b1;
					phase_d = PH_HDR;
				end
			endcase
		end else begin
			unique case (phase_q)
				PH_HDR: begin
					if (!data_byte[HDR_VALID_BIT]) begin
						err_d = 1'b1;
					end else begin
						ck_d  = LK_DEFINITE;
						tag_d = hdr_tag;
						if (data_byte[HDR_NEWFMT_BIT]) begin
							phase_d = PH_NEWLEN;
						end else if (data_byte[1:0] == OLD_LEN_CTX) begin
							if (!cfg.ctx_en) begin
								err_d = 1'b1;
							end else begin
								ck_d    = LK_CONTEXT;
								rem_d   = '0;
								phase_d = PH_CONTEXT;
							end
						end else begin
							acc_d   = '0;
							left_d  = old_left;
							phase_d = PH_MULTI;
						end
					end
				end
				PH_NEWLEN, PH_TWO, PH_MULTI: begin
					if (phase_q == PH_NEWLEN && !fin_go) begin
						if (data_byte <= NEW_TWO_MAX) begin
							acc_d   = {{(ACC_W-13){1'b0}}, data_byte[4:0], 8'd0} + NEW_TWO_OFFSET;
							phase_d = PH_TWO;
						end else begin
							acc_d   = '0;
							left_d  = 3'd4;
							phase_d = PH_MULTI;
						end
					end else if (phase_q == PH_MULTI) begin
						acc_d  = fin_len;
						left_d = left_dec;
					end
					if (fin_go) begin
						if (fin_over) begin
							err_d   = 1'b1;
							phase_d = PH_HDR;
						end else begin
							ck_d    = fin_part ? LK_PARTIAL : LK_DEFINITE;
							rem_d   = fin_len[LENGTH_WIDTH-1:0];
							phase_d = fin_zero ? PH_HDR : PH_BODY;
						end
					end
				end
				PH_BODY: begin
					rem_d = rem_dec;
					if (rem_dec == '0) begin
						phase_d = chained ? PH_NEWLEN : PH_HDR;
					end
				end
				PH_CONTEXT: ;
				default:    phase_d = PH_HDR;
			endcase
		end
	end

	// Result of this item.
	always_comb begin
		res       = '0;
		res.kind  = K_BODY;
		res.lk    = LK_DEFINITE;
		res.err   = E_NONE;
		res.tag   = tag_q;
		if (action == ACT_EOF) begin
			res.valid = 1'b1;
			unique case (phase_q)
				PH_HDR: begin
					res.kind = K_END;
					res.tag  = '0;
				end
				PH_CONTEXT: begin
					res.kind = K_END;
					res.lk   = LK_CONTEXT;
				end
				default: begin
					res.kind = K_ERROR;
					res.err  = E_TRUNCATED;
				end
			endcase
		end else begin
			unique case (phase_q)
				PH_HDR: begin
					if (!data_byte[HDR_VALID_BIT]) begin
						res.valid = 1'b1;
						res.kind  = K_ERROR;
						res.err   = E_NOT_HEADER;
					end else if (!data_byte[HDR_NEWFMT_BIT] && data_byte[1:0] == OLD_LEN_CTX) begin
						res.valid = 1'b1;
						res.tag   = hdr_tag;
						if (!cfg.ctx_en) begin
							res.kind = K_ERROR;
							res.err  = E_NO_CONTEXT;
						end else begin
							res.kind = K_HEADER;
							res.lk   = LK_CONTEXT;
						end
					end
				end
				PH_NEWLEN, PH_TWO, PH_MULTI: begin
					if (fin_go) begin
						if (fin_over) begin
							res.valid = 1'b1;
							res.kind  = K_ERROR;
							res.err   = E_BAD_LENGTH;
						end else if (chained) begin
							// A chained chunk header only shows when it ends the packet.
							res.valid = fin_zero;
							res.kind  = K_HEADER;
							res.last  = 1'b1;
						end else begin
							res.valid = 1'b1;
							res.kind  = K_HEADER;
							res.len   = fin_len[CHUNK_W-1:0];
							res.lk    = fin_part ? LK_PARTIAL : LK_DEFINITE;
							res.last  = fin_zero;
						end
					end
				end
				PH_BODY: begin
					res.valid = 1'b1;
					res.body  = data_byte;
					res.lk    = ck_q;
					res.last  = (rem_dec == '0) && !chained;
				end
				PH_CONTEXT: begin
					res.valid = 1'b1;
					res.body  = data_byte;
					res.lk    = LK_CONTEXT;
				end
				default: ;
			endcase
		end
		if (!live) begin
			res.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			tag_q   <= '0;
			rem_q   <= '0;
			acc_q   <= '0;
			left_q  <= '0;
			ck_q    <= LK_DEFINITE;
			err_q   <= 1'b0;
		end else if (live) begin
			phase_q <= phase_d;
			tag_q   <= tag_d;
			rem_q   <= rem_d;
			acc_q   <= acc_d;
			left_q  <= left_d;
			ck_q    <= ck_d;
			err_q   <= err_d;
		end
	end

	// Once an error is latched, nothing more comes out until reset.
	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |-> !res.valid)
		else $error("result produced after latched error");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q)
		else $error("latched error cleared without reset");

	a_err_latches: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.kind == K_ERROR) |=> err_q)
		else $error("error result did not latch the error");

	a_body_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY) |-> (rem_q != '0))
		else $error("body phase with no bytes remaining");

endmodule

FILE: hw/rtl/pgp_packet_header_deframer.sv
// Top level of the packet header deframer: input register, parse state machine,
// result register and APB configuration port.
// Depends on pgpd_pkg, pgpd_in_if, pgpd_out_if, pgpd_apb_regs and pgpd_hdr_fsm.
//
//   Channel   Direction  Handshake           Carries
//   stream    in         valid/ready         action, data_byte
//   result    out        valid/ready         kind, packet_tag, body_byte, chunk_length,
//                                            length_kind, last_in_packet, error_code
//   APB       in         psel/penable/pready allow_context_length, max_chunk_length
//
// One transaction is taken per clock cycle unless a stalled result fills both registers;
// the rate is set by the single parse step between the input register and the result register.
// A result reaches the result channel through the input register and the result register.
// Reset is asynchronous and active low; it clears the parse state, the latched error
// and the valid flags and resets the APB registers; transactions are taken once it ends.
// A stalled result holds in the result register while one more input item waits
// in the input register; ready on the stream falls only when both are full.
module pgp_packet_header_deframer #(
	parameter int unsigned LENGTH_WIDTH = pgpd_pkg::LENGTH_WIDTH_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pgpd_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [pgpd_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [pgpd_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	pgpd_in_if.sink                          stream,
	pgpd_out_if.source                       result
);
	import pgpd_pkg::*;

	cfg_t cfg;
	res_t res;

	// Input register (stage 1).
	logic       valid_s1;
	logic       action_s1;
	logic [7:0] byte_s1;

	// Result register.
	logic               out_valid_q;
	kind_t              kind_q;
	logic [5:0]         tag_q;
	logic [7:0]         body_q;
	logic [CHUNK_W-1:0] len_q;
	lk_t                lk_q;
	logic               last_q;
	err_t               err_q;

	logic out_free;
	logic step;
	logic in_take;

	pgpd_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The result register can take a new result when it is empty or being read
	// in this cycle. The item in stage 1 is processed exactly when it can move on,
	// whether or not it produces a result.
	assign out_free     = !out_valid_q || result.ready;
	assign step         = valid_s1 && out_free;
	assign stream.ready = !valid_s1 || out_free;
	assign in_take      = stream.valid && stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			action_s1 <= stream.action;
			byte_s1   <= stream.data_byte;
		end
	end

	pgpd_hdr_fsm #(
		.LENGTH_WIDTH (LENGTH_WIDTH)
	) u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.action    (action_s1),
		.data_byte (byte_s1),
		.cfg       (cfg),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			kind_q <= res.kind;
			tag_q  <= res.tag;
			body_q <= res.body;
			len_q  <= res.len;
			lk_q   <= res.lk;
			last_q <= res.last;
			err_q  <= res.err;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.kind           = kind_q;
	assign result.packet_tag     = tag_q;
	assign result.body_byte      = body_q;
	assign result.chunk_length   = len_q;
	assign result.length_kind    = lk_q;
	assign result.last_in_packet = last_q;
	assign result.error_code     = err_q;

	// A new result is only written into a free result register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> out_free)
		else $error("result register overwritten while held");

	// An item held in stage 1 behind a stalled result stays put.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> (valid_s1 && $stable(byte_s1) && $stable(action_s1)))
		else $error("stage 1 item lost during stall");

	// A stalled result keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |=> (out_valid_q && $stable(kind_q) && $stable(body_q)))
		else $error("held result changed during stall");

endmodule

FILE: verif/pgpd_deframe_checker.sv
`timescale 1ns / 1ps
// Watches the stream, result and configuration ports of the packet header deframer,
// predicts every result and compares it field by field. Depends on pgpd_pkg and both channels.
module pgpd_deframe_checker #(
	parameter int unsigned LENGTH_WIDTH = pgpd_pkg::LENGTH_WIDTH_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic                             pready,
	input  logic [pgpd_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [pgpd_pkg::APB_DATA_W-1:0]  pwdata,
	pgpd_in_if                               stream,
	pgpd_out_if                              result,
	output int unsigned                      mismatches,
	output int unsigned                      results_awaited
);
	import pgpd_pkg::*;

	localparam logic [63:0] LEN_MASK = (64'd1 << LENGTH_WIDTH) - 64'd1;

	// Shadow of the registers and of the parse state.
	logic                    ctx_en;
	logic [CHUNK_W-1:0]      len_limit;
	phase_t                  ph;
	logic [5:0]              cur_tag;
	logic [LENGTH_WIDTH-1:0] remaining;
	logic [ACC_W-1:0]        acc;
	logic [2:0]              bytes_left;
	lk_t                     ck;
	logic                    err_latched;

	res_t awaited_results[$];

	function automatic res_t make_result(kind_t k, logic [5:0] tag, logic [7:0] body,
		logic [CHUNK_W-1:0] len, lk_t lk, logic last, err_t err);
		res_t r;
		r.valid = 1'b1;
		r.kind  = k;
		r.tag   = tag;
		r.body  = body;
		r.len   = len;
		r.lk    = lk;
		r.last  = last;
		r.err   = err;
		return r;
	endfunction

	function automatic res_t flag_error(err_t code);
		err_latched = 1'b1;
		ph = PH_HDR;
		return make_result(K_ERROR, cur_tag, 8'd0, '0, LK_DEFINITE, 1'b0, code);
	endfunction

	// Apart from a length error, a chained chunk length only reports when it ends the packet with zero.
	function automatic void close_length(input logic [63:0] len, input bit partial,
		output bit has, output res_t r);
		bit          chained;
		logic [63:0] lim;
		r = '0;
		has = 1'b1;
		chained = (ck == LK_PARTIAL);
		lim = 64'(len_limit);
		if (lim > LEN_MASK)
			lim = LEN_MASK;
		if (len > lim) begin
			r = flag_error(E_BAD_LENGTH);
		end else begin
			ck = partial ? LK_PARTIAL : LK_DEFINITE;
			remaining = len[LENGTH_WIDTH-1:0];
			if (chained) begin
				if (len == 64'd0) begin
					ph = PH_HDR;
					r = make_result(K_HEADER, cur_tag, 8'd0, '0, LK_DEFINITE, 1'b1, E_NONE);
				end else begin
					ph = PH_BODY;
					has = 1'b0;
				end
			end else begin
				ph = (len == 64'd0) ? PH_HDR : PH_BODY;
				r = make_result(K_HEADER, cur_tag, 8'd0, len[CHUNK_W-1:0], ck,
					len == 64'd0, E_NONE);
			end
		end
	endfunction

	function automatic void parse_item(input logic act, input logic [7:0] b,
		output bit has, output res_t r);
		lk_t  lk;
		logic last;
		r = '0;
		has = 1'b0;
		if (err_latched)
			return;
		if (act == ACT_EOF) begin
			has = 1'b1;
			if (ph == PH_HDR) begin
				r = make_result(K_END, 6'd0, 8'd0, '0, LK_DEFINITE, 1'b0, E_NONE);
			end else if (ph == PH_CONTEXT) begin
				ph = PH_HDR;
				r = make_result(K_END, cur_tag, 8'd0, '0, LK_CONTEXT, 1'b0, E_NONE);
			end else begin
				r = flag_error(E_TRUNCATED);
			end
			return;
		end
		case (ph)
			PH_HDR: begin
				if (!b[HDR_VALID_BIT]) begin
					has = 1'b1;
					r = flag_error(E_NOT_HEADER);
				end else if (b[HDR_NEWFMT_BIT]) begin
					ck = LK_DEFINITE;
					cur_tag = b[5:0];
					ph = PH_NEWLEN;
				end else begin
					ck = LK_DEFINITE;
					cur_tag = {2'b00, b[5:2]};
					if (b[1:0] == OLD_LEN_CTX) begin
						has = 1'b1;
						if (!ctx_en) begin
							r = flag_error(E_NO_CONTEXT);
						end else begin
							ck = LK_CONTEXT;
							remaining = '0;
							ph = PH_CONTEXT;
							r = make_result(K_HEADER, cur_tag, 8'd0, '0, LK_CONTEXT, 1'b0,
								E_NONE);
						end
					end else begin
						acc = '0;
						bytes_left = (b[1:0] == OLD_LEN_1) ? 3'd1 :
							(b[1:0] == OLD_LEN_2) ? 3'd2 : 3'd4;
						ph = PH_MULTI;
					end
				end
			end
			PH_NEWLEN: begin
				if (b <= NEW_ONE_MAX) begin
					close_length(64'(b), 1'b0, has, r);
				end else if (b <= NEW_TWO_MAX) begin
					acc = (({24'd0, b} - NEW_TWO_OFFSET) << 8) + NEW_TWO_OFFSET;
					ph = PH_TWO;
				end else if (b == NEW_FIVE) begin
					acc = '0;
					bytes_left = 3'd4;
					ph = PH_MULTI;
				end else begin
					close_length(64'd1 << b[4:0], 1'b1, has, r);
				end
			end
			PH_TWO: close_length(64'(acc) + 64'(b), 1'b0, has, r);
			PH_MULTI: begin
				acc = {acc[ACC_W-9:0], b};
				bytes_left = bytes_left - 3'd1;
				if (bytes_left == 3'd0)
					close_length(64'(acc), 1'b0, has, r);
			end
			PH_BODY: begin
				lk = ck;
				last = 1'b0;
				remaining = remaining - LENGTH_WIDTH'(1);
				if (remaining == '0) begin
					if (ck == LK_PARTIAL) begin
						ph = PH_NEWLEN;
					end else begin
						ph = PH_HDR;
						last = 1'b1;
					end
				end
				has = 1'b1;
				r = make_result(K_BODY, cur_tag, b, '0, lk, last, E_NONE);
			end
			PH_CONTEXT: begin
				has = 1'b1;
				r = make_result(K_BODY, cur_tag, b, '0, LK_CONTEXT, 1'b0, E_NONE);
			end
			default: ph = PH_HDR;
		endcase
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches = mismatches + 1;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bit   has;
		res_t r;
		res_t want;
		if (!arst_n) begin
			ctx_en      = 1'b0;
			len_limit   = LEN_LIMIT_RESET;
			ph          = PH_HDR;
			cur_tag     = '0;
			remaining   = '0;
			acc         = '0;
			bytes_left  = '0;
			ck          = LK_DEFINITE;
			err_latched = 1'b0;
			mismatches  = 0;
			awaited_results.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_LEN_LIMIT)
					len_limit = pwdata[CHUNK_W-1:0];
				else
					ctx_en = pwdata[0];
			end
			if (result.valid && result.ready) begin
				if (awaited_results.size() == 0) begin
					$error("result transaction with no result awaited (kind %0d)",
						result.kind);
					mismatches = mismatches + 1;
				end else begin
					want = awaited_results.pop_front();
					check_field("kind", want.kind, result.kind);
					check_field("packet_tag", want.tag, result.packet_tag);
					check_field("body_byte", want.body, result.body_byte);
					check_field("chunk_length", want.len, result.chunk_length);
					check_field("length_kind", want.lk, result.length_kind);
					check_field("last_in_packet", want.last, result.last_in_packet);
					check_field("error_code", want.err, result.error_code);
				end
			end
			if (stream.valid && stream.ready) begin
				parse_item(stream.action, stream.data_byte, has, r);
				if (has)
					awaited_results.push_back(r);
			end
		end
		results_awaited = awaited_results.size();
	end
endmodule

FILE: verif/pgp_packet_header_deframer_test.sv
`timescale 1ns / 1ps
// Top of the packet header deframer testbench: clock, reset, stream stimulus, result
// back-pressure and register writes. Depends on pgpd_pkg, both channels and the checker.
module pgp_packet_header_deframer_test;
	import pgpd_pkg::*;

	localparam realtime     CLK_PERIOD     = 4ns;
	localparam int unsigned RESET_CYCLES   = 10;
	localparam int unsigned PHASE_ITEMS    = 350;
	localparam int unsigned HOLDOFF_CYCLES = 80;
	localparam int unsigned DRAIN_LIMIT    = 2000;
	// Lets any item that makes no result leave the pipeline after the results have
	// drained, before the registers change.
	localparam int unsigned SETTLE_CYCLES  = 6;
	localparam int unsigned NOISE_ITEMS    = 24;
	localparam int unsigned RUN_LIMIT_NS   = 2_000_000;

	// Encodings that the package leaves out: the four-byte old-format length type and
	// the base of the new-format partial chunk bytes.
	localparam logic [1:0] OLD_LEN_4    = 2'd2;
	localparam logic [7:0] PARTIAL_BASE = 8'd224;

	typedef enum int unsigned {
		SH_NEW,
		SH_OLD_1,
		SH_OLD_2,
		SH_OLD_4,
		SH_PARTIAL,
		SH_CONTEXT,
		SH_END
	} shape_t;

	typedef enum int unsigned {
		NL_ONE,
		NL_TWO,
		NL_FIVE
	} new_len_t;

	typedef enum int unsigned {
		FAULT_NOT_HEADER,
		FAULT_LENGTH,
		FAULT_CONTEXT,
		FAULT_TRUNCATED
	} fault_t;

	typedef struct packed {
		logic       action;
		logic [7:0] data;
	} stream_item_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [APB_ADDR_W-1:0]  paddr;
	logic [APB_DATA_W-1:0]  pwdata;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;

	int unsigned check_failures;
	int unsigned results_awaited;

	// Idling is switched off for the last part of the run. The long hold-off of the
	// result channel is requested here and counted out in the sink process.
	bit gaps_on;
	bit holdoff_req;

	// What the stimulus knows of the registers, so that it builds packets that pass.
	bit          cfg_allow;
	int unsigned cfg_limit;

	stream_item_t send_q[$];

	pgpd_in_if  stream_ch ();
	pgpd_out_if result_ch ();

	pgp_packet_header_deframer i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.stream  (stream_ch),
		.result  (result_ch)
	);

	pgpd_deframe_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.stream          (stream_ch),
		.result          (result_ch),
		.mismatches      (check_failures),
		.results_awaited (results_awaited)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int unsigned min_u(int unsigned a, int unsigned b);
		return (a < b) ? a : b;
	endfunction

	// Lengths lean toward the low end of the range so that bodies stay short, with an
	// occasional pick across the whole range.
	function automatic int unsigned pick_len(int unsigned lo, int unsigned hi);
		int unsigned upper;
		upper = ($urandom_range(0, 3) != 0 && hi > lo + 12) ? lo + 12 : hi;
		return $urandom_range(upper, lo);
	endfunction

	task automatic push_byte(input logic [7:0] b);
		send_q.push_back('{ACT_BYTE, b});
	endtask

	// The data byte of an end-of-input transaction is ignored, so it is random.
	task automatic push_eof();
		send_q.push_back('{ACT_EOF, 8'($urandom)});
	endtask

	task automatic push_body(input int unsigned count);
		repeat (count) push_byte(8'($urandom));
	endtask

	// Queues a new-format definite length in one of its three encodings and returns
	// the length chosen, which never exceeds the limit.
	task automatic push_new_length(input int unsigned lim, output int unsigned len);
		new_len_t    form;
		int unsigned v;
		form = new_len_t'($urandom_range(0, 2));
		if (form == NL_TWO && lim < 192)
			form = NL_ONE;
		case (form)
			NL_ONE: begin
				len = pick_len(0, min_u(lim, 191));
				push_byte(len[7:0]);
			end
			NL_TWO: begin
				len = pick_len(192, min_u(lim, 450));
				v = len - 192;
				push_byte(8'(NEW_TWO_OFFSET) + v[15:8]);
				push_byte(v[7:0]);
			end
			default: begin
				len = pick_len(0, min_u(lim, 300));
				push_byte(NEW_FIVE);
				push_byte(len[31:24]);
				push_byte(len[23:16]);
				push_byte(len[15:8]);
				push_byte(len[7:0]);
			end
		endcase
	endtask

	// One well-formed packet (or a clean end of input) that fits the current limit.
	// Indeterminate packets run to an end of input, which closes the stream.
	task automatic queue_random_packet();
		shape_t      shape;
		int unsigned len;
		int unsigned k;
		int unsigned kmax;
		logic [5:0]  tag;
		tag = 6'($urandom);
		case ($urandom_range(0, 9))
			0, 1, 2: shape = SH_NEW;
			3:       shape = SH_OLD_1;
			4:       shape = SH_OLD_2;
			5:       shape = SH_OLD_4;
			6, 7:    shape = SH_PARTIAL;
			8:       shape = cfg_allow ? SH_CONTEXT : SH_NEW;
			default: shape = SH_END;
		endcase
		case (shape)
			SH_NEW: begin
				push_byte({2'b11, tag});
				push_new_length(cfg_limit, len);
				push_body(len);
			end
			SH_OLD_1: begin
				len = pick_len(0, min_u(cfg_limit, 255));
				push_byte({2'b10, tag[3:0], OLD_LEN_1});
				push_byte(len[7:0]);
				push_body(len);
			end
			SH_OLD_2: begin
				len = pick_len(0, min_u(cfg_limit, 300));
				push_byte({2'b10, tag[3:0], OLD_LEN_2});
				push_byte(len[15:8]);
				push_byte(len[7:0]);
				push_body(len);
			end
			SH_OLD_4: begin
				len = pick_len(0, min_u(cfg_limit, 300));
				push_byte({2'b10, tag[3:0], OLD_LEN_4});
				push_byte(len[31:24]);
				push_byte(len[23:16]);
				push_byte(len[15:8]);
				push_byte(len[7:0]);
				push_body(len);
			end
			SH_PARTIAL: begin
				// The largest chunk that the limit lets through, kept small.
				kmax = 0;
				while (kmax < 6 && (2 << kmax) <= cfg_limit)
					kmax++;
				push_byte({2'b11, tag});
				repeat ($urandom_range(1, 3)) begin
					k = $urandom_range(0, kmax);
					push_byte(PARTIAL_BASE + 8'(k));
					push_body(1 << k);
				end
				push_new_length(cfg_limit, len);
				push_body(len);
			end
			SH_CONTEXT: begin
				push_byte({2'b10, tag[3:0], OLD_LEN_CTX});
				push_body(pick_len(0, 20));
				push_eof();
			end
			default: push_eof();
		endcase
	endtask

	task automatic queue_random_phase(input int unsigned count);
		while (send_q.size() < count)
			queue_random_packet();
	endtask

	// Called at a falling edge. One register write: setup cycle, then access cycle,
	// done at the rising edge where pready is seen high.
	task automatic write_register(input logic reg_index, input logic [APB_DATA_W-1:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {reg_index, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic apply_settings(input bit allow, input int unsigned limit);
		write_register(REG_CTX_EN, APB_DATA_W'(allow));
		write_register(REG_LEN_LIMIT, APB_DATA_W'(limit));
		cfg_allow = allow;
		cfg_limit = limit;
	endtask

	// Offers every queued item, with random idle bursts while gaps are on, then waits
	// for the results to drain and for the pipeline to empty. Called at a falling edge;
	// a new item replaces the last at the same edge; with no idle burst, valid stays high.
	task automatic play_and_drain();
		stream_item_t it;
		int unsigned  gap;
		int unsigned  waited;
		while (send_q.size() > 0) begin
			it = send_q.pop_front();
			gap = (gaps_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 7) : 0;
			if (gap > 0) begin
				stream_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			stream_ch.valid     = 1'b1;
			stream_ch.action    = it.action;
			stream_ch.data_byte = it.data;
			@(posedge clk);
			while (!stream_ch.ready)
				@(posedge clk);
			@(negedge clk);
		end
		stream_ch.valid = 1'b0;
		waited = 0;
		while (results_awaited != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Result back-pressure. Stalls come in random bursts while gaps are on; the
	// hold-off keeps ready low long enough for the result register and the input
	// register to fill, so the block stops taking stream transactions.
	initial begin : result_sink
		int unsigned stall;
		result_ch.ready = 1'b1;
		forever begin
			@(negedge clk);
			if (holdoff_req) begin
				result_ch.ready = 1'b0;
				repeat (HOLDOFF_CYCLES) @(negedge clk);
				holdoff_req = 1'b0;
				result_ch.ready = 1'b1;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 7);
				result_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
				result_ch.ready = 1'b1;
			end
		end
	end

	initial begin : watchdog
		#(RUN_LIMIT_NS * 1ns);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		fault_t     fault;
		logic [5:0] tag;
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		stream_ch.valid     = 1'b0;
		stream_ch.action    = ACT_BYTE;
		stream_ch.data_byte = 8'd0;
		gaps_on             = 1'b1;
		holdoff_req         = 1'b0;
		cfg_allow           = 1'b0;
		cfg_limit           = 32'(LEN_LIMIT_RESET);
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// Directed part, with indeterminate lengths allowed and the reset limit.
		apply_settings(1'b1, 32'(LEN_LIMIT_RESET));
		// End of input before any packet is a clean end with tag zero.
		push_eof();
		// New format, highest tag, zero length: the header itself ends the packet.
		push_byte(8'hFF);
		push_byte(8'h00);
		// New format with a five-byte length of one.
		push_byte(8'hC3);
		push_byte(NEW_FIVE);
		push_byte(8'h00);
		push_byte(8'h00);
		push_byte(8'h00);
		push_byte(8'h01);
		push_byte(8'h00);
		// Old format, tag zero, one-byte length of zero.
		push_byte(8'h80);
		push_byte(8'h00);
		// Old format, highest old tag, two-byte length of zero.
		push_byte(8'hBD);
		push_byte(8'h00);
		push_byte(8'h00);
		// Partial chunks of two and one bytes, then a chained zero length that ends
		// the packet with its own header result.
		push_byte(8'hCB);
		push_byte(PARTIAL_BASE + 8'd1);
		push_byte(8'h11);
		push_byte(8'h22);
		push_byte(PARTIAL_BASE);
		push_byte(8'h44);
		push_byte(8'h00);
		// Indeterminate length: body bytes until end of input.
		push_byte(8'h8B);
		push_byte(8'h66);
		push_byte(8'h77);
		push_eof();
		play_and_drain();

		// Random phases over several register settings.
		queue_random_phase(PHASE_ITEMS);
		play_and_drain();

		apply_settings(1'b0, 16);
		holdoff_req = 1'b1;
		queue_random_phase(PHASE_ITEMS);
		play_and_drain();

		apply_settings(1'b1, 1);
		queue_random_phase(PHASE_ITEMS);
		play_and_drain();

		apply_settings(1'b1, 200);
		queue_random_phase(PHASE_ITEMS);
		play_and_drain();

		// Last part without idling. An error latches until reset, and reset comes
		// only once, so the single error of the run closes it, followed by items that
		// must all be swallowed.
		gaps_on = 1'b0;
		apply_settings(1'b0, 32'(LEN_LIMIT_RESET));
		queue_random_phase(PHASE_ITEMS);
		tag = 6'($urandom);
		fault = fault_t'($urandom_range(0, 3));
		case (fault)
			FAULT_NOT_HEADER: push_byte(8'($urandom_range(127, 0)));
			FAULT_LENGTH: begin
				push_byte({2'b11, tag});
				if ($urandom_range(0, 1) == 0) begin
					// Partial chunk far beyond the limit.
					push_byte(PARTIAL_BASE + 8'($urandom_range(30, 25)));
				end else begin
					cfg_limit = $urandom_range(32'hFFFF_FFFF, 32'(LEN_LIMIT_RESET) + 1);
					push_byte(NEW_FIVE);
					push_byte(cfg_limit[31:24]);
					push_byte(cfg_limit[23:16]);
					push_byte(cfg_limit[15:8]);
					push_byte(cfg_limit[7:0]);
				end
			end
			FAULT_CONTEXT: push_byte({2'b10, tag[3:0], OLD_LEN_CTX});
			default: begin
				// End of input right after the header byte or inside the body.
				push_byte({2'b11, tag});
				if ($urandom_range(0, 1) == 0) begin
					push_byte(8'd5);
					push_body($urandom_range(0, 4));
				end
				push_eof();
			end
		endcase
		repeat (NOISE_ITEMS) begin
			if ($urandom_range(0, 3) == 0)
				push_eof();
			else
				push_byte(8'($urandom));
		end
		play_and_drain();

		if (results_awaited != 0)
			$error("%0d awaited results never arrived", results_awaited);
		if (check_failures == 0 && results_awaited == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
